>>> src/cpualu_pkg.sv
// Package with the command codes, flag positions and shared types of the 8-bit ALU.
package cpualu_pkg;

    localparam int CmdWidth  = 5;
    localparam int DataWidth = 16;
    localparam int ByteWidth = 8;
    localparam int IdxWidth  = 3;
    localparam int FlagWidth = 4;

    typedef logic [CmdWidth-1:0]  cmd_t;
    typedef logic [DataWidth-1:0] word_t;
    typedef logic [ByteWidth-1:0] byte_t;
    typedef logic [IdxWidth-1:0]  idx_t;
    typedef logic [FlagWidth-1:0] flags_t;

    // Flag bit positions within flags_t.
    localparam int FlagZ = 3;
    localparam int FlagN = 2;
    localparam int FlagH = 1;
    localparam int FlagC = 0;

    localparam cmd_t CMD_ADD   = 5'd0;
    localparam cmd_t CMD_ADC   = 5'd1;
    localparam cmd_t CMD_SUB   = 5'd2;
    localparam cmd_t CMD_SBC   = 5'd3;
    localparam cmd_t CMD_AND   = 5'd4;
    localparam cmd_t CMD_OR    = 5'd5;
    localparam cmd_t CMD_XOR   = 5'd6;
    localparam cmd_t CMD_CP    = 5'd7;
    localparam cmd_t CMD_INC   = 5'd8;
    localparam cmd_t CMD_DEC   = 5'd9;
    localparam cmd_t CMD_ADD16 = 5'd10;
    localparam cmd_t CMD_SWAP  = 5'd11;
    localparam cmd_t CMD_RLC   = 5'd12;
    localparam cmd_t CMD_RL    = 5'd13;
    localparam cmd_t CMD_RRC   = 5'd14;
    localparam cmd_t CMD_RR    = 5'd15;
    localparam cmd_t CMD_SLA   = 5'd16;
    localparam cmd_t CMD_SRA   = 5'd17;
    localparam cmd_t CMD_SRL   = 5'd18;
    localparam cmd_t CMD_BIT   = 5'd19;
    localparam cmd_t CMD_SET   = 5'd20;
    localparam cmd_t CMD_RES   = 5'd21;

    // One captured instruction waiting in the input register.
    typedef struct packed {
        cmd_t  command;
        word_t operand_a;
        word_t operand_b;
        idx_t  bit_index;
    } instr_t;

endpackage

>>> src/cpu_alu_with_flags_top.sv
// Top level of the 8-bit ALU with kept Z/N/H/C flag register and valid/stall channels.
//
// An instruction passes through the input register and then the result register, and a
// stalled output can hold it in either. A new instruction is taken every cycle while the
// input is not stalled. The flag register is updated as an instruction moves from the
// input register into the result register, so the next instruction sees the flags of
// the one before it. Results come out in order. A stalled output holds the pipeline,
// and the input stalls only when both registers are full and the output is not taken.
module cpu_alu_with_flags_top
    import cpualu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  cmd_t   command,
    input  word_t  operand_a,
    input  word_t  operand_b,
    input  idx_t   bit_index,
    output logic   out_valid,
    input  logic   out_stall,
    output word_t  result,
    output flags_t flags_out
);

    logic   s1_valid_reg;
    logic   s1_valid_next;
    instr_t s1_instr_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    word_t  result_reg;
    flags_t flags_out_reg;
    flags_t flag_reg;
    flags_t flag_next;
    word_t  core_result;
    flags_t core_flags;
    logic   out_free;
    logic   s1_move;
    logic   in_take;

    // The result register can take a new value when it is empty or being read.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    cpualu_core u_core (
        .instr     (s1_instr_reg),
        .flags_in  (flag_reg),
        .result    (core_result),
        .flags_out (core_flags)
    );

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);
    assign flag_next      = s1_move ? core_flags : flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_instr_reg <= '{command:   command,
                              operand_a: operand_a,
                              operand_b: operand_b,
                              bit_index: bit_index};
        end
        if (s1_move)
        begin
            result_reg    <= core_result;
            flags_out_reg <= core_flags;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign flags_out = flags_out_reg;

    // The flag register changes only when an instruction is retired into the result register.
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(flag_reg))
        else $error("flag register changed without an instruction moving");

    // A shown result always carries the flags currently kept.
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flags_out_reg == flag_reg))
        else $error("output flags differ from kept flags");

    // A result appears only after an instruction sat in the input register.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an instruction");

    // A waiting instruction is not lost while the output is stalled.
    a_s1_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("instruction dropped during output stall");

endmodule

>>> src/cpualu_core.sv
// Combinational datapath of the ALU: one instruction and the stored flags in, result and flags out.
module cpualu_core
    import cpualu_pkg::*;
(
    input  instr_t instr,
    input  flags_t flags_in,
    output word_t  result,
    output flags_t flags_out
);

    byte_t       a;
    byte_t       b;
    logic        cin;
    logic        add_cin;
    logic        sub_cin;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic [16:0] wide_sum;
    logic [12:0] wide_half;
    byte_t       bit_mask;
    byte_t       res8;
    word_t       res_w;
    flags_t      fl;

    assign a   = instr.operand_a[ByteWidth-1:0];
    assign b   = instr.operand_b[ByteWidth-1:0];
    assign cin = flags_in[FlagC];

    assign add_cin = (instr.command == CMD_ADC) & cin;
    assign sub_cin = (instr.command == CMD_SBC) & cin;

    // Carry-in is added at full width, so 0xFF plus carry still sets C and H.
    assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
    // The top bit of each difference is the borrow.
    assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, sub_cin};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cin};

    assign wide_sum  = {1'b0, instr.operand_a} + {1'b0, instr.operand_b};
    assign wide_half = {1'b0, instr.operand_a[11:0]} + {1'b0, instr.operand_b[11:0]};

    assign bit_mask = byte_t'(1) << instr.bit_index;

    always_comb
    begin
        res8  = '0;
        res_w = '0;
        fl    = flags_in;
        unique case (instr.command)
            CMD_ADD, CMD_ADC:
            begin
                res8 = add_sum[7:0];
                fl   = {res8 == '0, 1'b0, add_half[4], add_sum[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                res8 = (instr.command == CMD_CP) ? a : sub_diff[7:0];
                fl   = {sub_diff[7:0] == '0, 1'b1, sub_half[4], sub_diff[8]};
            end
            CMD_AND:
            begin
                res8 = a & b;
                fl   = {res8 == '0, 1'b0, 1'b1, 1'b0};
            end
            CMD_OR:
            begin
                res8 = a | b;
                fl   = {res8 == '0, 3'b000};
            end
            CMD_XOR:
            begin
                res8 = a ^ b;
                fl   = {res8 == '0, 3'b000};
            end
            CMD_INC:
            begin
                res8 = a + 8'd1;
                fl   = {res8 == '0, 1'b0, a[3:0] == 4'hF, cin};
            end
            CMD_DEC:
            begin
                res8 = a - 8'd1;
                fl   = {res8 == '0, 1'b1, a[3:0] == 4'h0, cin};
            end
            CMD_ADD16:
            begin
                res_w = wide_sum[15:0];
                fl    = {flags_in[FlagZ], 1'b0, wide_half[12], wide_sum[16]};
            end
            CMD_SWAP:
            begin
                res8 = {a[3:0], a[7:4]};
                fl   = {res8 == '0, 3'b000};
            end
            CMD_RLC:
            begin
                res8 = {a[6:0], a[7]};
                fl   = {res8 == '0, 2'b00, a[7]};
            end
            CMD_RL:
            begin
                res8 = {a[6:0], cin};
                fl   = {res8 == '0, 2'b00, a[7]};
            end
            CMD_RRC:
            begin
                res8 = {a[0], a[7:1]};
                fl   = {res8 == '0, 2'b00, a[0]};
            end
            CMD_RR:
            begin
                res8 = {cin, a[7:1]};
                fl   = {res8 == '0, 2'b00, a[0]};
            end
            CMD_SLA:
            begin
                res8 = {a[6:0], 1'b0};
                fl   = {res8 == '0, 2'b00, a[7]};
            end
            CMD_SRA:
            begin
                res8 = {a[7], a[7:1]};
                fl   = {res8 == '0, 2'b00, a[0]};
            end
            CMD_SRL:
            begin
                res8 = {1'b0, a[7:1]};
                fl   = {res8 == '0, 2'b00, a[0]};
            end
            CMD_BIT:
            begin
                res8 = a;
                fl   = {(a & bit_mask) == '0, 1'b0, 1'b1, cin};
            end
            CMD_SET:
            begin
                res8 = a | bit_mask;
            end
            CMD_RES:
            begin
                res8 = a & ~bit_mask;
            end
            default:
            begin
                // Unused codes give zero and leave the flags alone.
                res8 = '0;
                fl   = flags_in;
            end
        endcase
    end

    assign result    = (instr.command == CMD_ADD16) ? res_w : {8'd0, res8};
    assign flags_out = fl;

endmodule
